[sv/assert_macros.svh]
// assertion macros used by the deframer rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`endif

[sv/pdxc_pkg.sv]
// types and constants of the packet deframer with xor check
`timescale 1ns / 1ps

package pdxc_pkg;

  localparam logic [2:0] HEADER_BYTES = 3'd6;
  localparam logic [7:0] SUM_OK       = 8'h00;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_TRAILER = 2'd2;
  localparam logic [1:0] PH_UNUSED  = 2'd3;

  localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
  localparam logic [2:0] KIND_OK        = 3'd1;
  localparam logic [2:0] KIND_SUM_ERROR = 3'd2;
  localparam logic [2:0] KIND_CLEAN_END = 3'd3;
  localparam logic [2:0] KIND_TRUNCATED = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  packet_type;
    logic [15:0] payload_length;
  } result_t;

endpackage

[sv/packet_deframer_xor_check_unit.sv]
// packet deframer with even/odd xor check, input register and result register
// an input transfer is captured in the input register, then its result in the output register
// throughput: one byte per cycle while out_stall is low, set by the single register-to-register pass
// an input transfer is taken while a result waits only if the input register is empty, and is held there
// reset: synchronous, clears deframer state and both valid flags
`timescale 1ns / 1ps
`include "assert_macros.svh"

module packet_deframer_xor_check_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  packet_type,
  output logic [15:0] payload_length
);

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_end;

  logic [1:0]  phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] remaining, remaining_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  xor_sums [2];
  logic [7:0]  xor_sums_next [2];
  logic        odd_position, odd_position_next;
  logic [1:0]  trailer_left, trailer_left_next;

  pdxc_pkg::result_t res;

  logic        out_free;
  logic        advance;
  logic [1:0]  phase_eff;
  logic [2:0]  idx_inc;
  logic [15:0] rem_dec;
  logic [1:0]  tl_dec;

  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;

  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    length_reg_next   = length_reg;
    remaining_next    = remaining;
    type_reg_next     = type_reg;
    xor_sums_next[0]  = xor_sums[0];
    xor_sums_next[1]  = xor_sums[1];
    odd_position_next = odd_position;
    trailer_left_next = trailer_left;
    res               = '0;
    idx_inc           = 3'(header_index + 3'd1);
    rem_dec           = 16'(remaining - 16'd1);
    tl_dec            = (trailer_left != 2'd0) ? 2'(trailer_left - 2'd1) : 2'd0;

    if (phase inside {pdxc_pkg::PH_PAYLOAD, pdxc_pkg::PH_TRAILER}) begin
      phase_eff = phase;
    end else begin
      phase_eff = pdxc_pkg::PH_HEADER;
    end
    phase_next = phase_eff;

    if (hold_end) begin
      res.valid = 1'b1;
      if (phase_eff == pdxc_pkg::PH_HEADER && header_index == 3'd0) begin
        res.kind = pdxc_pkg::KIND_CLEAN_END;
      end else begin
        res.kind           = pdxc_pkg::KIND_TRUNCATED;
        res.packet_type    = type_reg;
        res.payload_length = length_reg;
        phase_next         = pdxc_pkg::PH_HEADER;
        header_index_next  = 3'd0;
      end
    end else begin
      case (phase_eff)
        pdxc_pkg::PH_PAYLOAD: begin
          xor_sums_next[odd_position] = xor_sums[odd_position] ^ hold_byte;
          odd_position_next           = !odd_position;
          remaining_next              = rem_dec;
          if (rem_dec == 16'd0) begin
            phase_next        = pdxc_pkg::PH_TRAILER;
            trailer_left_next = 2'(2'd2 + {1'b0, !odd_position});
          end
          res.valid          = 1'b1;
          res.kind           = pdxc_pkg::KIND_PAYLOAD;
          res.payload_byte   = hold_byte;
          res.packet_type    = type_reg;
          res.payload_length = length_reg;
        end
        pdxc_pkg::PH_TRAILER: begin
          xor_sums_next[odd_position] = xor_sums[odd_position] ^ hold_byte;
          odd_position_next           = !odd_position;
          trailer_left_next           = tl_dec;
          if (tl_dec == 2'd0) begin
            phase_next        = pdxc_pkg::PH_HEADER;
            header_index_next = 3'd0;
            res.valid         = 1'b1;
            if (xor_sums_next[0] == pdxc_pkg::SUM_OK &&
                xor_sums_next[1] == pdxc_pkg::SUM_OK) begin
              res.kind = pdxc_pkg::KIND_OK;
            end else begin
              res.kind = pdxc_pkg::KIND_SUM_ERROR;
            end
            res.packet_type    = type_reg;
            res.payload_length = length_reg;
          end
        end
        default: begin
          // start of packet clears length and type and restarts the sums and parity with the first byte
          if (header_index == 3'd0) begin
            xor_sums_next[0]  = 8'h00;
            xor_sums_next[1]  = 8'h00;
            length_reg_next   = 16'h0000;
            type_reg_next     = 8'h00;
            xor_sums_next[0]  = hold_byte;
            odd_position_next = 1'b1;
          end else begin
            xor_sums_next[odd_position] = xor_sums[odd_position] ^ hold_byte;
            odd_position_next           = !odd_position;
          end
          if (header_index == 3'd2) begin
            length_reg_next = {hold_byte, length_reg[7:0]};
          end else if (header_index == 3'd3) begin
            length_reg_next = {length_reg[15:8], hold_byte};
          end else if (header_index == 3'd4) begin
            type_reg_next = hold_byte;
          end
          header_index_next = idx_inc;
          if (idx_inc >= pdxc_pkg::HEADER_BYTES) begin
            header_index_next = 3'd0;
            remaining_next    = length_reg_next;
            if (length_reg_next == 16'd0) begin
              phase_next        = pdxc_pkg::PH_TRAILER;
              trailer_left_next = 2'(2'd2 + {1'b0, odd_position_next});
            end else begin
              phase_next = pdxc_pkg::PH_PAYLOAD;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      out_valid    <= 1'b0;
      phase        <= pdxc_pkg::PH_HEADER;
      header_index <= 3'd0;
      length_reg   <= 16'h0000;
      remaining    <= 16'h0000;
      type_reg     <= 8'h00;
      xor_sums[0]  <= 8'h00;
      xor_sums[1]  <= 8'h00;
      odd_position <= 1'b0;
      trailer_left <= 2'd0;
    end else begin
      if (!in_stall) begin
        hold_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= advance && res.valid;
      end
      if (advance) begin
        phase        <= phase_next;
        header_index <= header_index_next;
        length_reg   <= length_reg_next;
        remaining    <= remaining_next;
        type_reg     <= type_reg_next;
        xor_sums[0]  <= xor_sums_next[0];
        xor_sums[1]  <= xor_sums_next[1];
        odd_position <= odd_position_next;
        trailer_left <= trailer_left_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= data_byte;
      hold_end  <= stream_end;
    end
    if (advance && res.valid) begin
      kind           <= res.kind;
      payload_byte   <= res.payload_byte;
      packet_type    <= res.packet_type;
      payload_length <= res.payload_length;
    end
  end

  `ASSERT_NEVER(a_phase_code, clk, rst, phase == pdxc_pkg::PH_UNUSED)
  `ASSERT_NEVER(a_header_index, clk, rst, header_index >= pdxc_pkg::HEADER_BYTES)
  `ASSERT_IMPLIES(a_trailer_count, clk, rst, phase == pdxc_pkg::PH_TRAILER, trailer_left != 2'd0)
  `ASSERT_IMPLIES(a_payload_zero, clk, rst,
                  out_valid && kind != pdxc_pkg::KIND_PAYLOAD, payload_byte == 8'h00)
  `ASSERT_NEXT(a_stall_holds, clk, rst, in_stall, hold_valid)

endmodule
